// ===== src/gnpe_pkg.sv =====
// Shared types and codes for the graph node position extractor.
// Holds the item structs, the parser state struct and the phase and result codes.
// No dependencies.
`default_nettype none

package gnpe_pkg;

  // parser phases
  localparam logic [3:0] PH_LEGEND = 4'd0;
  localparam logic [3:0] PH_LCLOSE = 4'd1;
  localparam logic [3:0] PH_NODE   = 4'd2;
  localparam logic [3:0] PH_NUM    = 4'd3;
  localparam logic [3:0] PH_KIND   = 4'd4;
  localparam logic [3:0] PH_SKIPB  = 4'd5;
  localparam logic [3:0] PH_LABEL  = 4'd6;
  localparam logic [3:0] PH_OPTQ   = 4'd7;
  localparam logic [3:0] PH_NAME   = 4'd8;
  localparam logic [3:0] PH_POS    = 4'd9;
  localparam logic [3:0] PH_X      = 4'd10;
  localparam logic [3:0] PH_COMMA  = 4'd11;
  localparam logic [3:0] PH_Y      = 4'd12;

  // result kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_COORDS = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // final status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EOF     = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [23:0] SAT24 = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_byte;
    logic [23:0] x_hundredths;
    logic [23:0] y_hundredths;
    logic [1:0]  parse_status;
    logic        last_of_run;
  } result_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  match_position;
    logic [23:0] x_accumulator;
    logic [23:0] y_accumulator;
    logic [1:0]  fraction_digits;
    logic        point_seen;
    logic        field_started;
    logic        halted;
  } parse_state_t;

endpackage

`default_nettype wire

// ===== src/gnpe_step.sv =====
// Next-state and result logic for one text item of the position extractor.
// Purely combinational; depends on gnpe_pkg for the state and item structs.
`default_nettype none

module gnpe_step
  import gnpe_pkg::*;
(
  input  parse_state_t st,
  input  text_item_t   item,
  output parse_state_t st_next,
  output result_item_t res_a,
  output result_item_t res_b,
  output logic [1:0]   res_count
);

  // pattern searched in each seeking phase
  function automatic logic [7:0] pattern_char(input logic [3:0] ph, input logic [3:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (ph)
      PH_LEGEND: begin
        case (p)
          4'd0:    ch = "c";
          4'd1:    ch = "l";
          4'd2:    ch = "u";
          4'd3:    ch = "s";
          4'd4:    ch = "t";
          4'd5:    ch = "e";
          4'd6:    ch = "r";
          4'd7:    ch = "L";
          4'd8:    ch = "e";
          4'd9:    ch = "g";
          4'd10:   ch = "e";
          4'd11:   ch = "n";
          4'd12:   ch = "d";
          4'd13:   ch = " ";
          default: ch = "{";
        endcase
      end
      PH_LCLOSE: ch = "}";
      PH_NODE: begin
        case (p)
          4'd0:    ch = "n";
          4'd1:    ch = "o";
          4'd2:    ch = "d";
          default: ch = "e";
        endcase
      end
      PH_SKIPB: ch = "]";
      PH_LABEL: begin
        case (p)
          4'd0:    ch = "l";
          4'd1:    ch = "a";
          4'd2:    ch = "b";
          4'd3:    ch = "e";
          4'd4:    ch = "l";
          default: ch = "=";
        endcase
      end
      PH_POS: begin
        case (p)
          4'd0:    ch = "p";
          4'd1:    ch = "o";
          4'd2:    ch = "s";
          4'd3:    ch = "=";
          default: ch = 8'h22;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // index of the last character of the pattern
  function automatic logic [3:0] pattern_last(input logic [3:0] ph);
    logic [3:0] l;
    case (ph)
      PH_LEGEND: l = 4'd14;
      PH_NODE:   l = 4'd3;
      PH_LABEL:  l = 4'd5;
      PH_POS:    l = 4'd4;
      default:   l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_digit(c) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           (c == "_") || (c == ".") || (c == "+") || (c == "-");
  endfunction

  function automatic parse_state_t go_to(input parse_state_t s, input logic [3:0] ph);
    parse_state_t r;
    r = s;
    r.phase           = ph;
    r.match_position  = 4'd0;
    r.field_started   = 1'b0;
    r.point_seen      = 1'b0;
    r.fraction_digits = 2'd0;
    return r;
  endfunction

  function automatic result_item_t status_res(input logic [1:0] code);
    result_item_t r;
    r = '0;
    r.result_kind  = KIND_STATUS;
    r.parse_status = code;
    return r;
  endfunction

  // number unit: one digit step on the coordinate being read
  logic [23:0] acc_sel;
  logic [27:0] mac;
  logic [23:0] mac_sat;
  logic [30:0] acc_x100;
  logic [27:0] acc_x10;
  logic [23:0] finished;

  always_comb begin
    acc_sel  = (st.phase == PH_Y) ? st.y_accumulator : st.x_accumulator;
    mac      = {4'd0, acc_sel} * 28'd10 + {24'd0, item.text_byte[3:0] - 4'd0};
    mac_sat  = (mac > {4'd0, SAT24}) ? SAT24 : mac[23:0];
    acc_x100 = {7'd0, acc_sel} * 31'd100;
    acc_x10  = {4'd0, acc_sel} * 28'd10;
    case (st.fraction_digits)
      2'd0:    finished = (acc_x100 > {7'd0, SAT24}) ? SAT24 : acc_x100[23:0];
      2'd1:    finished = (acc_x10 > {4'd0, SAT24}) ? SAT24 : acc_x10[23:0];
      default: finished = acc_sel;
    endcase
  end

  // phase logic, at most two passes when a byte ends one field and starts the next
  always_comb begin
    parse_state_t s;
    result_item_t res [2];
    logic [1:0]   n;
    logic [7:0]   c;
    logic         pass;
    logic         fail_req;
    logic [1:0]   fail_code;
    logic         hit;
    logic [3:0]   p;
    logic [3:0]   last;
    logic         digit_in;
    logic         point_in;

    s         = st;
    res[0]    = '0;
    res[1]    = '0;
    n         = 2'd0;
    c         = item.text_byte;
    pass      = 1'b1;
    fail_req  = 1'b0;
    fail_code = ST_OK;
    hit       = 1'b0;
    p         = 4'd0;
    last      = 4'd0;
    digit_in  = is_digit(c);
    point_in  = (c == ".");

    if (st.halted) begin
      pass = 1'b0;
    end else if (item.end_of_text) begin
      pass     = 1'b0;
      fail_req = 1'b1;
      case (st.phase)
        PH_NODE: fail_code = ST_OK;
        PH_NUM, PH_NAME, PH_X: fail_code = st.field_started ? ST_EOF : ST_MISSING;
        PH_Y: begin
          if (!st.field_started) begin
            fail_code = ST_MISSING;
          end else begin
            res[0]              = '0;
            res[0].result_kind  = KIND_COORDS;
            res[0].x_hundredths = st.x_accumulator;
            res[0].y_hundredths = finished;
            n                   = 2'd1;
            fail_code           = ST_OK;
          end
        end
        default: fail_code = ST_EOF;
      endcase
    end

    for (int k = 0; k < 2; k++) begin
      if (pass && !fail_req) begin
        pass = 1'b0;
        // shared text search step
        last = pattern_last(s.phase);
        p    = (s.match_position > last) ? 4'd0 : s.match_position;
        hit  = 1'b0;
        case (s.phase)
          PH_LEGEND, PH_LCLOSE, PH_NODE, PH_SKIPB, PH_LABEL, PH_POS: begin
            if (c == pattern_char(s.phase, p)) begin
              if (p == last) begin
                hit = 1'b1;
              end else begin
                s.match_position = p + 4'd1;
              end
            end else begin
              s.match_position = 4'd0;
            end
          end
          default: hit = 1'b0;
        endcase

        case (s.phase)
          PH_LEGEND: if (hit) s = go_to(s, PH_LCLOSE);
          PH_LCLOSE: if (hit) s = go_to(s, PH_NODE);
          PH_NODE:   if (hit) s = go_to(s, PH_NUM);
          PH_SKIPB:  if (hit) s = go_to(s, PH_NODE);
          PH_LABEL:  if (hit) s = go_to(s, PH_OPTQ);
          PH_POS: begin
            if (hit) begin
              s = go_to(s, PH_X);
              s.x_accumulator = 24'd0;
            end
          end
          PH_NUM: begin
            if (digit_in) begin
              s.field_started = 1'b1;
            end else if (!s.field_started) begin
              fail_req  = 1'b1;
              fail_code = ST_MISSING;
            end else begin
              s    = go_to(s, PH_KIND);
              pass = 1'b1;
            end
          end
          PH_KIND: begin
            if (c == "-") begin
              s = go_to(s, PH_SKIPB);
            end else if (c == "[") begin
              s = go_to(s, PH_LABEL);
            end else if (!is_space(c)) begin
              fail_req  = 1'b1;
              fail_code = ST_BAD;
            end
          end
          PH_OPTQ: begin
            s = go_to(s, PH_NAME);
            if (c != 8'h22) pass = 1'b1;
          end
          PH_NAME: begin
            if (is_name_char(c)) begin
              res[n[0]]             = '0;
              res[n[0]].result_kind = KIND_NAME;
              res[n[0]].name_byte   = c;
              n                     = n + 2'd1;
              s.field_started       = 1'b1;
            end else if (!s.field_started) begin
              fail_req  = 1'b1;
              fail_code = ST_MISSING;
            end else begin
              s    = go_to(s, PH_POS);
              pass = 1'b1;
            end
          end
          PH_X, PH_Y: begin
            if (digit_in) begin
              if (!s.point_seen || (s.fraction_digits < 2'd2)) begin
                if (s.phase == PH_X) s.x_accumulator = mac_sat;
                else s.y_accumulator = mac_sat;
              end
              if (s.point_seen && (s.fraction_digits < 2'd2)) begin
                s.fraction_digits = s.fraction_digits + 2'd1;
              end
              s.field_started = 1'b1;
            end else if (point_in) begin
              if (s.point_seen) begin
                fail_req  = 1'b1;
                fail_code = ST_BAD;
              end else begin
                s.point_seen    = 1'b1;
                s.field_started = 1'b1;
              end
            end else if (!s.field_started) begin
              fail_req  = 1'b1;
              fail_code = ST_MISSING;
            end else if (s.phase == PH_X) begin
              s.x_accumulator = finished;
              s    = go_to(s, PH_COMMA);
              pass = 1'b1;
            end else begin
              s.y_accumulator           = finished;
              res[n[0]]                 = '0;
              res[n[0]].result_kind     = KIND_COORDS;
              res[n[0]].x_hundredths    = s.x_accumulator;
              res[n[0]].y_hundredths    = finished;
              n                         = n + 2'd1;
              s    = go_to(s, PH_NODE);
              pass = 1'b1;
            end
          end
          PH_COMMA: begin
            if (c == ",") begin
              s = go_to(s, PH_Y);
              s.y_accumulator = 24'd0;
            end else if (!is_space(c)) begin
              fail_req  = 1'b1;
              fail_code = ST_BAD;
            end
          end
          default: pass = 1'b0;
        endcase
      end
    end

    // final status closes the run and halts the parser
    if (fail_req) begin
      res[n[0]] = status_res(fail_code);
      n         = n + 2'd1;
      s.halted  = 1'b1;
    end

    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;

    st_next   = s;
    res_a     = res[0];
    res_b     = res[1];
    res_count = n;
  end

endmodule

`default_nettype wire

// ===== src/gnpe_outq.sv =====
// Four-entry result queue of the position extractor; takes up to two items a cycle.
// Depends on gnpe_pkg for the result item struct.
`default_nettype none

module gnpe_outq
  import gnpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_item_t push_a,
  input  result_item_t push_b,
  input  logic [1:0]   push_count,
  input  logic         pop,
  output result_item_t head,
  output logic         not_empty,
  output logic         has_room
);

  result_item_t entries [4];
  logic [1:0]   wr_ptr;
  logic [1:0]   rd_ptr;
  logic [2:0]   fill;

  // storage writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push_a;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push_b;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill + {1'b0, push_count} - {2'd0, pop};
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (fill != 3'd0);
  assign has_room  = (fill <= 3'd2);

endmodule

`default_nettype wire

// ===== src/graph_node_position_extractor.sv =====
// Graph node position extractor: takes a graph description one byte per item and
// streams out node name bytes, node coordinates in hundredths and one final status.
// An item is taken every cycle while text_stall is low; it waits in the input
// register and its results in the result queue. An item with two results (end
// of text while y is being read) pushes both at once. The rate is set by the
// four-entry result queue: the input register moves on while the queue holds at
// most two results, so text_stall is raised only once results have backed up
// behind a stalled result side. After the final status every further item is
// taken and dropped until reset. Depends on gnpe_pkg, gnpe_step and gnpe_outq.
`default_nettype none

module graph_node_position_extractor
  import gnpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_stall,
  input  text_item_t   text_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_data
);

  text_item_t   text_q;
  logic         text_full;
  parse_state_t state;
  parse_state_t state_next;
  result_item_t res_a;
  result_item_t res_b;
  logic [1:0]   res_count;
  logic         advance;
  logic         room;
  logic         pop;

  assign advance    = text_full && room;
  assign text_stall = text_full && !room;
  assign pop        = result_valid && !result_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_full <= 1'b0;
    end else if (!text_full || advance) begin
      text_full <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && (!text_full || advance)) text_q <= text_data;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_LEGEND, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  gnpe_step u_step (
    .st        (state),
    .item      (text_q),
    .st_next   (state_next),
    .res_a     (res_a),
    .res_b     (res_b),
    .res_count (res_count)
  );

  // result queue
  gnpe_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_a     (res_a),
    .push_b     (res_b),
    .push_count (advance ? res_count : 2'd0),
    .pop        (pop),
    .head       (result_data),
    .not_empty  (result_valid),
    .has_room   (room)
  );

endmodule

`default_nettype wire

// ===== src/gnpe_checker.sv =====
// Port-level checks for the graph node position extractor, bound to the top level.
// Depends on gnpe_pkg for the item structs and result codes.
`default_nettype none

module gnpe_checker
  import gnpe_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         text_stall,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result_data
);

  // a held result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result item changed while stalled");

  // input is only held back by a backlog of results
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid)
    else $error("text stalled with no result pending");

  // the final status always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.result_kind == KIND_STATUS) |-> result_data.last_of_run)
    else $error("final status not last of run");

  // name items carry no coordinates or status
  a_name_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.result_kind == KIND_NAME) |->
      (result_data.x_hundredths == 24'd0) && (result_data.y_hundredths == 24'd0) &&
      (result_data.parse_status == ST_OK))
    else $error("name item with stray fields");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered after reset");

endmodule

bind graph_node_position_extractor gnpe_checker u_gnpe_checker (.*);

`default_nettype wire
